/* rtl/pwlccl_pkg.sv */
`timescale 1ns / 1ps

package pwlccl_pkg;

   // Command codes carried on req_cmd.
   typedef enum logic {
      CMD_KNOT_WRITE = 1'b0,
      CMD_PIXEL_MAP  = 1'b1
   } cmd_type;

   // Channel codes of a knot write.
   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2,
      CH_NONE  = 2'd3
   } channel_type;

   localparam int CHANNEL_COUNT = 3;
   localparam int KNOT_COUNT    = 64;
   localparam int KNOT_BITS     = 6;

   // Levels at or above this take the last knot.
   localparam logic [7:0] LEVEL_TOP = 8'd253;

   typedef logic [7:0]           level_type;
   typedef logic [KNOT_BITS-1:0] knot_idx_type;
   typedef logic [1:0]           frac_type;

   // Knot pair and fractional position of one input level.
   typedef struct packed {
      knot_idx_type knot_lo;
      knot_idx_type knot_hi;
      frac_type     frac;
   } split_type;

   // Knot m stands for level 1+4m, so the segment comes from level-1.
   function automatic split_type level_split(input level_type level);
      split_type s;
      level_type lm1;
      lm1 = level - 8'd1;
      priority if (level == 8'd0) begin
         s.knot_lo = '0;
         s.frac    = '0;
      end else if (level >= LEVEL_TOP) begin
         s.knot_lo = knot_idx_type'(KNOT_COUNT - 1);
         s.frac    = '0;
      end else begin
         s.knot_lo = lm1[7:2];
         s.frac    = lm1[1:0];
      end
      // The upper knot wraps at the last knot, where it is not used.
      s.knot_hi = s.knot_lo + knot_idx_type'(1);
      return s;
   endfunction

   // lo + (frac*(hi-lo))/4 with the division truncating toward zero.
   function automatic level_type interp(input level_type lo, input level_type hi,
                                        input frac_type frac);
      logic signed [8:0]  diff;
      logic signed [10:0] prod;
      logic signed [10:0] quot;
      diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
      prod = {{2{diff[8]}}, diff} * $signed({9'd0, frac});
      quot = (prod + (prod[10] ? 11'sd3 : 11'sd0)) >>> 2;
      if (frac == 2'd0) begin
         return lo;
      end
      return lo + quot[7:0];
   endfunction

endpackage

/* rtl/piecewise_linear_color_curve_lut.sv */
// Maps one pixel per clock through per-stripe, per-channel tone curves of
// 64 knots each; knot writes share the same command port. A command is taken
// whenever start is high and busy is low, and busy is low at all times outside
// reset, so one word (knot write or pixel) enters every cycle. A pixel's result
// appears on the rsp_ ports, marked by rsp_strobe, for exactly one cycle, after the
// registered read of the knot memories and the interpolation into the output
// register. The receiver cannot stall the result. Knot writes give no result. Knot
// memories are not cleared; every knot a pixel needs must be written first.
`timescale 1ns / 1ps

module piecewise_linear_color_curve_lut #(
   parameter int IMAGE_WIDTH  = 512,
   parameter int STRIPE_COUNT = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [1:0] req_knot_stripe,
   input  logic [1:0] req_knot_channel,
   input  logic [5:0] req_knot_index,
   input  logic [7:0] req_knot_value,
   input  logic [8:0] req_pixel_column,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   output logic       rsp_strobe,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out
);

   localparam int StripeWidth = IMAGE_WIDTH / STRIPE_COUNT;
   localparam int StripeBits  = (STRIPE_COUNT > 1) ? $clog2(STRIPE_COUNT) : 1;
   localparam int MemDepth    = STRIPE_COUNT * pwlccl_pkg::KNOT_COUNT;
   localparam int AddrBits    = $clog2(MemDepth);
   localparam int Chans       = pwlccl_pkg::CHANNEL_COUNT;

   logic                  accept;
   logic                  pixel_go;
   logic                  knot_go;
   logic [StripeBits-1:0] pixel_stripe;

   pwlccl_pkg::level_type level_in [Chans];
   pwlccl_pkg::split_type split    [Chans];

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   pwlccl_pkg::level_type s1_lo_ff   [Chans];
   pwlccl_pkg::level_type s1_hi_ff   [Chans];
   pwlccl_pkg::frac_type  s1_frac_ff [Chans];

   logic                  rsp_strobe_ff;
   pwlccl_pkg::level_type rsp_level_ff [Chans];
   pwlccl_pkg::level_type rsp_level_in [Chans];

   // Every word is taken outside reset.
   assign busy     = reset;
   assign accept   = start && !busy;
   assign pixel_go = accept && (req_cmd == pwlccl_pkg::CMD_PIXEL_MAP);
   assign knot_go  = accept && (req_cmd == pwlccl_pkg::CMD_KNOT_WRITE)
                     && (int'(req_knot_stripe) < STRIPE_COUNT);

   assign level_in[0] = req_red_in;
   assign level_in[1] = req_green_in;
   assign level_in[2] = req_blue_in;

   // Stripe of the pixel column, saturating at the last stripe.
   always_comb begin
      pixel_stripe = '0;
      for (int i = 1; i < STRIPE_COUNT; i++) begin
         if (int'(req_pixel_column) >= i * StripeWidth) begin
            pixel_stripe = StripeBits'(i);
         end
      end
   end

   // Knot pair and fraction for each channel level.
   always_comb begin
      for (int c = 0; c < Chans; c++) begin
         split[c] = pwlccl_pkg::level_split(level_in[c]);
      end
   end

   // One knot memory per channel: one write port, two registered read ports.
   for (genvar ch = 0; ch < Chans; ch++) begin : g_chan
      logic [7:0]          knot_mem [MemDepth];
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic [AddrBits-1:0] rd_addr_lo;
      logic [AddrBits-1:0] rd_addr_hi;

      assign wr_en      = knot_go && (int'(req_knot_channel) == ch);
      assign wr_addr    = AddrBits'({req_knot_stripe, req_knot_index});
      assign rd_addr_lo = AddrBits'({pixel_stripe, split[ch].knot_lo});
      assign rd_addr_hi = AddrBits'({pixel_stripe, split[ch].knot_hi});

      always_ff @(posedge clock) begin
         if (wr_en) begin
            knot_mem[wr_addr] <= req_knot_value;
         end
         s1_lo_ff[ch]   <= knot_mem[rd_addr_lo];
         s1_hi_ff[ch]   <= knot_mem[rd_addr_hi];
         s1_frac_ff[ch] <= split[ch].frac;
      end
   end

   // Interpolation between the two knots read for each channel.
   always_comb begin
      for (int c = 0; c < Chans; c++) begin
         rsp_level_in[c] = pwlccl_pkg::interp(s1_lo_ff[c], s1_hi_ff[c], s1_frac_ff[c]);
      end
   end

   assign s1_valid_in = pixel_go;

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      for (int c = 0; c < Chans; c++) begin
         rsp_level_ff[c] <= rsp_level_in[c];
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_red_out   = rsp_level_ff[0];
   assign rsp_green_out = rsp_level_ff[1];
   assign rsp_blue_out  = rsp_level_ff[2];

endmodule

/* rtl/pwlccl_checker.sv */
`timescale 1ns / 1ps

module pwlccl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_cmd,
   input logic rsp_strobe
);

   logic pixel_taken;
   logic knot_taken;

   assign pixel_taken = start && !busy && (req_cmd == pwlccl_pkg::CMD_PIXEL_MAP);
   assign knot_taken  = start && !busy && (req_cmd == pwlccl_pkg::CMD_KNOT_WRITE);

   // Every pixel word gives a result on rsp_strobe.
   a_pixel_result: assert property (@(posedge clock) disable iff (reset)
      pixel_taken |-> ##2 rsp_strobe)
      else $error("pixel word gave no result");

   // A result is only ever the answer to a pixel word.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(pixel_taken, 2))
      else $error("result without a pixel word");

   // A knot write never gives a result.
   a_knot_silent: assert property (@(posedge clock) disable iff (reset)
      knot_taken |-> ##2 !rsp_strobe)
      else $error("knot write gave a result");

   // Nothing comes out in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_strobe)
      else $error("result right after reset");

endmodule

bind piecewise_linear_color_curve_lut pwlccl_checker u_pwlccl_checker (.*);
